// ===== src/mbcrc_pkg.sv =====
`default_nettype none
package mbcrc_pkg;

   localparam int MaxFrame = 256;
   localparam int LenWidth = 9;
   localparam int CrcWidth = 16;
   localparam int ByteWidth = 8;

   localparam logic [CrcWidth-1:0] CRC_SEED = 16'hFFFF;
   localparam logic [CrcWidth-1:0] CRC_POLY = 16'hA001;
   localparam logic [CrcWidth-1:0] CRC_LOW_MASK = 16'h00FF;
   localparam logic [LenWidth-1:0] MAX_FRAME_LEN = LenWidth'(MaxFrame);

   localparam logic CMD_RX = 1'b0;
   localparam logic CMD_TX = 1'b1;

   typedef struct packed {
      logic step;
      logic frame_start;
   } step_ctl_type;

   typedef struct packed {
      logic                 command;
      logic                 frame_start;
      logic [ByteWidth-1:0] data_byte;
      logic [LenWidth-1:0]  frame_length;
   } req_item_type;

   function automatic logic [CrcWidth-1:0] crc_fold(input logic [CrcWidth-1:0] crc,
                                                   input logic [ByteWidth-1:0] data);
      logic [CrcWidth-1:0] c;
      c = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/mbcrc_rx_side.sv =====
`default_nettype none
module mbcrc_rx_side
   import mbcrc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire step_ctl_type         ctl,
   input  wire logic [ByteWidth-1:0] data_byte,
   output logic      [CrcWidth-1:0]  check_crc
);

   logic [CrcWidth-1:0] crc_ff, crc_in;
   logic [CrcWidth-1:0] dly0_ff, dly0_in;
   logic [CrcWidth-1:0] dly1_ff, dly1_in;
   logic [CrcWidth-1:0] dly2_ff, dly2_in;
   logic [CrcWidth-1:0] base_crc;
   logic [CrcWidth-1:0] base_d0;
   logic [CrcWidth-1:0] base_d1;

   always_comb begin
      base_crc = ctl.frame_start ? CRC_SEED : crc_ff;
      base_d0  = ctl.frame_start ? CRC_SEED : dly0_ff;
      base_d1  = ctl.frame_start ? CRC_SEED : dly1_ff;
      crc_in   = crc_ff;
      dly0_in  = dly0_ff;
      dly1_in  = dly1_ff;
      dly2_in  = dly2_ff;
      if (ctl.step) begin
         crc_in  = crc_fold(base_crc, data_byte);
         dly0_in = crc_in;
         dly1_in = base_d0;
         dly2_in = base_d1;
      end
   end

   assign check_crc = dly2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_SEED;
         dly0_ff <= '0;
         dly1_ff <= '0;
         dly2_ff <= '0;
      end else begin
         crc_ff  <= crc_in;
         dly0_ff <= dly0_in;
         dly1_ff <= dly1_in;
         dly2_ff <= dly2_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/mbcrc_tx_side.sv =====
`default_nettype none
module mbcrc_tx_side
   import mbcrc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire step_ctl_type         ctl,
   input  wire logic [ByteWidth-1:0] data_byte,
   input  wire logic [LenWidth-1:0]  frame_length,
   output logic      [ByteWidth-1:0] tx_byte,
   output logic                      tx_sent,
   output logic      [CrcWidth-1:0]  running_crc
);

   logic [CrcWidth-1:0] crc_ff, crc_in;
   logic [LenWidth-1:0] count_ff, count_in;
   logic [CrcWidth-1:0] base_crc;
   logic [LenWidth-1:0] base_count;
   logic [LenWidth-1:0] len;
   logic [LenWidth:0]   count_plus2;

   always_comb begin
      base_crc    = ctl.frame_start ? CRC_SEED : crc_ff;
      base_count  = ctl.frame_start ? '0 : count_ff;
      len         = (frame_length > MAX_FRAME_LEN) ? MAX_FRAME_LEN : frame_length;
      count_plus2 = {1'b0, base_count} + (LenWidth+1)'(2);
      crc_in      = crc_ff;
      count_in    = count_ff;
      tx_byte     = '0;
      tx_sent     = 1'b0;
      if (ctl.step) begin
         crc_in   = base_crc;
         count_in = base_count;
         if (base_count < len) begin
            if (count_plus2 < {1'b0, len}) begin
               tx_byte = data_byte;
               crc_in  = crc_fold(base_crc, data_byte);
            end else begin
               tx_byte = ByteWidth'(base_crc & CRC_LOW_MASK);
               crc_in  = base_crc >> ByteWidth;
            end
            tx_sent  = 1'b1;
            count_in = base_count + LenWidth'(1);
         end
      end
   end

   assign running_crc = crc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_SEED;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/modbus_rtu_crc_frame_engine.sv =====
// Modbus RTU CRC-16 engine with a receive side and a transmit side.
// Each request on the req_ channel carries one byte: req_tuser selects a
// received byte or a transmit step and flags a frame start, which reseeds
// that side's CRC state. Every request gives exactly one result on rsp_:
// the byte sent on a transmit step (flagged by rsp_tuser), the receive CRC
// as it stood two bytes back, and the running transmit CRC.
// A request is taken into an input register, and the CRC update runs
// combinationally between that register and the result register, which
// loads when it is empty or being read. One request is accepted per
// cycle when results are taken as fast as they come.
// When the receiver holds rsp_tready low, the result register holds its
// value and one more request may wait in the input register; after that
// req_tready drops until the result is taken.
// Reset empties both registers, sets both CRCs to 0xFFFF, clears the
// receive delay line and the transmit byte count.
`default_nettype none
module modbus_rtu_crc_frame_engine
   import mbcrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // data_byte[7:0], frame_length[16:8], zeros
   input  wire logic [1:0]  req_tuser,  // command[0], frame_start[1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,  // tx_byte[7:0], rx_check_crc[23:8],
                                        // tx_running_crc[39:24]
   output logic      [0:0]  rsp_tuser   // tx_sent[0]
);

   logic                 in_valid_ff, in_valid_in;
   req_item_type         item_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0] tx_byte_ff;
   logic                 tx_sent_ff;
   logic [CrcWidth-1:0]  rx_crc_out_ff;
   logic [CrcWidth-1:0]  tx_crc_out_ff;
   logic                 advance;
   logic                 req_fire;
   step_ctl_type         rx_ctl;
   step_ctl_type         tx_ctl;
   logic [ByteWidth-1:0] tx_byte;
   logic                 tx_sent;
   logic [CrcWidth-1:0]  rx_check_crc;
   logic [CrcWidth-1:0]  tx_running_crc;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign rx_ctl.step        = advance && (item_ff.command == CMD_RX);
   assign rx_ctl.frame_start = item_ff.frame_start;
   assign tx_ctl.step        = advance && (item_ff.command == CMD_TX);
   assign tx_ctl.frame_start = item_ff.frame_start;

   mbcrc_rx_side u_rx (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rx_ctl),
      .data_byte (item_ff.data_byte),
      .check_crc (rx_check_crc)
   );

   mbcrc_tx_side u_tx (
      .clock        (clock),
      .reset        (reset),
      .ctl          (tx_ctl),
      .data_byte    (item_ff.data_byte),
      .frame_length (item_ff.frame_length),
      .tx_byte      (tx_byte),
      .tx_sent      (tx_sent),
      .running_crc  (tx_running_crc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.command      <= req_tuser[0];
         item_ff.frame_start  <= req_tuser[1];
         item_ff.data_byte    <= req_tdata[7:0];
         item_ff.frame_length <= req_tdata[16:8];
      end
      if (advance) begin
         tx_byte_ff    <= tx_byte;
         tx_sent_ff    <= tx_sent;
         rx_crc_out_ff <= rx_check_crc;
         tx_crc_out_ff <= tx_running_crc;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {tx_crc_out_ff, rx_crc_out_ff, tx_byte_ff};
   assign rsp_tuser[0] = tx_sent_ff;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mbcrc_pkg::*;

   typedef struct packed {
      logic [15:0] tx_running_crc;
      logic [15:0] rx_check_crc;
      logic [7:0]  tx_byte;
      logic        tx_sent;
   } crc_result_type;

   typedef struct packed {
      req_item_type   req;
      logic           typed;
      crc_result_type want;
   } crc_row_type;

   localparam int unsigned ItemTarget = 850;
   localparam int unsigned HoldCycles = 150;
   localparam int unsigned DrainLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   logic [15:0] rx_run_crc = CRC_SEED;
   logic [15:0] rx_crc_line [3] = '{16'h0000, 16'h0000, 16'h0000};
   logic [15:0] tx_run_crc = CRC_SEED;
   logic [8:0]  tx_bytes_sent = '0;

   crc_result_type crc_results_due [$];
   crc_row_type    directed_rows [$];
   int unsigned mismatch_count = 0;
   int unsigned results_seen = 0;
   int unsigned requests_sent = 0;
   bit          sender_gaps_on = 1'b1;
   int unsigned big_frames_left = 2;

   modbus_rtu_crc_frame_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                   input logic [7:0] data);
      logic [15:0] c;
      logic        feedback;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = c[0] ^ data[i];
         c = c >> 1;
         if (feedback) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic crc_result_type predict_step(input req_item_type r);
      crc_result_type res;
      logic [8:0]     len;
      res = '0;
      len = (r.frame_length > MAX_FRAME_LEN) ? MAX_FRAME_LEN : r.frame_length;
      if (r.command == CMD_RX) begin
         if (r.frame_start) begin
            rx_run_crc = CRC_SEED;
            rx_crc_line = '{CRC_SEED, CRC_SEED, CRC_SEED};
         end
         rx_run_crc = modbus_crc_byte(rx_run_crc, r.data_byte);
         rx_crc_line[2] = rx_crc_line[1];
         rx_crc_line[1] = rx_crc_line[0];
         rx_crc_line[0] = rx_run_crc;
      end else begin
         if (r.frame_start) begin
            tx_run_crc = CRC_SEED;
            tx_bytes_sent = '0;
         end
         if (tx_bytes_sent < len) begin
            if (int'(tx_bytes_sent) + 2 < int'(len)) begin
               res.tx_byte = r.data_byte;
               tx_run_crc = modbus_crc_byte(tx_run_crc, r.data_byte);
            end else begin
               res.tx_byte = tx_run_crc[7:0];
               tx_run_crc = tx_run_crc >> 8;
            end
            res.tx_sent = 1'b1;
            tx_bytes_sent = tx_bytes_sent + 9'd1;
         end
      end
      res.rx_check_crc = rx_crc_line[2];
      res.tx_running_crc = tx_run_crc;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatch_count < 40) begin
         $display("mismatch: %s at result %0d, got %h, expected %h",
                  what, results_seen, got, want);
      end
      mismatch_count++;
   endtask

   task automatic offer_request(input req_item_type r, input logic typed,
                                input crc_result_type want);
      int unsigned    idle;
      crc_result_type due;
      idle = 0;
      if (sender_gaps_on) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: idle = 0;
            6, 7, 8: idle = $urandom_range(1, 3);
            default: idle = $urandom_range(5, 30);
         endcase
      end
      if (idle != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (idle - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, r.frame_length, r.data_byte};
      req_tuser <= {r.frame_start, r.command};
      do @(posedge clock); while (req_tready !== 1'b1);
      due = predict_step(r);
      if (typed) begin
         due = want;
      end
      crc_results_due.push_back(due);
      requests_sent++;
   endtask

   task automatic add_row(input logic cmd, input logic start, input logic [7:0] data,
                          input logic [8:0] len, input logic typed,
                          input logic [7:0] tx_byte, input logic sent,
                          input logic [15:0] rx_check, input logic [15:0] tx_crc);
      crc_row_type row;
      row.req = '{command: cmd, frame_start: start, data_byte: data, frame_length: len};
      row.typed = typed;
      row.want = '{tx_running_crc: tx_crc, rx_check_crc: rx_check, tx_byte: tx_byte,
                   tx_sent: sent};
      directed_rows.push_back(row);
   endtask

   task automatic send_rx_frame();
      req_item_type r;
      int unsigned  n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < n; i++) begin
         r.command = CMD_RX;
         r.frame_start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
         r.data_byte = 8'($urandom);
         r.frame_length = 9'($urandom);
         offer_request(r, 1'b0, '0);
      end
   endtask

   task automatic send_tx_frame();
      req_item_type r;
      int unsigned  len;
      int unsigned  steps;
      case ($urandom_range(0, 19))
         0: begin
            if (big_frames_left != 0) begin
               big_frames_left--;
               len = $urandom_range(256, 511);
            end else begin
               len = $urandom_range(257, 511);
            end
         end
         1, 2, 3, 4: len = $urandom_range(17, 64);
         default: len = $urandom_range(0, 16);
      endcase
      steps = ((len > MaxFrame) ? MaxFrame : len) + $urandom_range(0, 2);
      if (len > 64 && len > MaxFrame && big_frames_left == 0) begin
         steps = $urandom_range(1, 20);
      end
      for (int unsigned i = 0; i < steps; i++) begin
         r.command = CMD_TX;
         r.frame_start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
         r.data_byte = 8'($urandom);
         r.frame_length = ($urandom_range(0, 29) == 0) ? 9'($urandom) : 9'(len);
         offer_request(r, 1'b0, '0);
      end
   endtask

   initial begin
      req_item_type r;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(CMD_RX, 1'b0, 8'h00, 9'd0,   1'b1, 8'h00, 1'b0, 16'h0000, 16'hFFFF);
      add_row(CMD_TX, 1'b0, 8'hAA, 9'd0,   1'b1, 8'h00, 1'b0, 16'h0000, 16'hFFFF);
      add_row(CMD_TX, 1'b1, 8'h55, 9'd2,   1'b1, 8'hFF, 1'b1, 16'h0000, 16'h00FF);
      add_row(CMD_TX, 1'b0, 8'h55, 9'd2,   1'b1, 8'hFF, 1'b1, 16'h0000, 16'h0000);
      add_row(CMD_TX, 1'b0, 8'h00, 9'd2,   1'b1, 8'h00, 1'b0, 16'h0000, 16'h0000);
      add_row(CMD_RX, 1'b1, 8'hFF, 9'h1FF, 1'b1, 8'h00, 1'b0, 16'hFFFF, 16'h0000);
      add_row(CMD_RX, 1'b1, 8'h01, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_RX, 1'b0, 8'h03, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_RX, 1'b0, 8'h00, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_RX, 1'b0, 8'h00, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_RX, 1'b0, 8'h00, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_RX, 1'b0, 8'h0A, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_RX, 1'b0, 8'hC5, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_RX, 1'b0, 8'hCD, 9'd0,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b1, 8'h01, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'h03, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'h00, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'h00, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'h00, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'h0A, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'hFF, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'hFF, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b0, 8'hFF, 9'd8,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b1, 8'h00, 9'd1,   1'b0, '0, '0, '0, '0);
      add_row(CMD_TX, 1'b1, 8'hFF, 9'h1FF, 1'b0, '0, '0, '0, '0);

      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      while (requests_sent < ItemTarget) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_rx_frame();
            4, 5, 6, 7, 8: send_tx_frame();
            default: begin
               r = req_item_type'($urandom);
               offer_request(r, 1'b0, '0);
            end
         endcase
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      for (int unsigned i = 0; i < DrainLimit && crc_results_due.size() != 0; i++) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (crc_results_due.size() != 0) begin
         report_mismatch("results never delivered", crc_results_due.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // The receiver stalls at random, and once holds off long enough that the
   // block fills up and pushes back on its request side.
   initial begin
      int unsigned stall_left;
      int unsigned quiet_left;
      bit          hold_done;
      stall_left = 0;
      quiet_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen >= 120) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_done = 1'b1;
         end
         if (quiet_left != 0) begin
            quiet_left--;
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            case ($urandom_range(0, 39))
               0: quiet_left = $urandom_range(20, 80);
               1, 2, 3, 4, 5, 6: stall_left = $urandom_range(1, 3);
               7: stall_left = $urandom_range(5, 30);
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      crc_result_type due;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (crc_results_due.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata[31:0], 0);
         end else begin
            due = crc_results_due.pop_front();
            if (rsp_tdata[7:0] !== due.tx_byte) begin
               report_mismatch("tx_byte", rsp_tdata[7:0], due.tx_byte);
            end
            if (rsp_tuser[0] !== due.tx_sent) begin
               report_mismatch("tx_sent", rsp_tuser[0], due.tx_sent);
            end
            if (rsp_tdata[23:8] !== due.rx_check_crc) begin
               report_mismatch("rx_check_crc", rsp_tdata[23:8], due.rx_check_crc);
            end
            if (rsp_tdata[39:24] !== due.tx_running_crc) begin
               report_mismatch("tx_running_crc", rsp_tdata[39:24], due.tx_running_crc);
            end
         end
         results_seen++;
      end
   end

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
src/mbcrc_pkg.sv
src/mbcrc_rx_side.sv
src/mbcrc_tx_side.sv
src/modbus_rtu_crc_frame_engine.sv
tb/sv/testbench.sv
